// ===== src/bgbp_pkg.sv =====
// ----------------------------------------------------------------------------
// bgbp_pkg
// Shared constants and types of the bitmap font text parser: address and
// glyph index widths, clamp limits, result kinds and the stage structs.
// ----------------------------------------------------------------------------
package bgbp_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int ADDR_BITS  = 24;
    localparam int GLYPH_BITS = 16;

    localparam int W_LIMIT    = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
    localparam int HEIGHT_MAX = 128;
    localparam int AREA_BITS  = 15;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_BOX   = 2'd1,
        KIND_COUNT = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] pixel_address;
        logic [3:0]  pixel_bits;
        logic [3:0]  pixel_mask;
        logic [7:0]  box_width;
        logic [7:0]  box_height;
        logic [15:0] glyph_count;
        logic [15:0] glyph_number;
    } result_t;

endpackage

// ===== src/bgbp_in_stage.sv =====
// ----------------------------------------------------------------------------
// bgbp_in_stage
// Input register: holds one text byte request until the parser takes it.
// ----------------------------------------------------------------------------
module bgbp_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               pop,
    output bgbp_pkg::in_item_t item
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;

    assign s_ready = aresetn && (!in_valid_reg || pop);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (pop) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_text_byte;
        end
    end

    assign item.valid     = in_valid_reg;
    assign item.text_byte = byte_reg;

endmodule

// ===== src/bgbp_parse.sv =====
// ----------------------------------------------------------------------------
// bgbp_parse
// Line parser: keyword matching, decimal tokens, hex rows and the pixel
// address arithmetic. One byte is consumed per advance.
// ----------------------------------------------------------------------------
module bgbp_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  bgbp_pkg::in_item_t item,
    input  logic               out_free,
    output logic               advance,
    output logic               res_load,
    output bgbp_pkg::result_t  res
);

    localparam int AW = bgbp_pkg::ADDR_BITS;
    localparam int GW = bgbp_pkg::GLYPH_BITS;
    localparam int RW = bgbp_pkg::AREA_BITS;

    typedef enum logic [2:0] {
        CL_START   = 3'd0,
        CL_FONT    = 3'd1,
        CL_CHARS   = 3'd2,
        CL_BITMAP  = 3'd3,
        CL_ENDCHAR = 3'd4,
        CL_DATA    = 3'd5,
        CL_NUM     = 3'd6,
        CL_SKIP    = 3'd7
    } line_class_t;

    localparam logic [7:0] KW_FONT [16] = '{"F", "O", "N", "T", "B", "O", "U", "N",
                                           "D", "I", "N", "G", "B", "O", "X", " "};
    localparam logic [7:0] KW_CHARS [8] = '{"C", "H", "A", "R", "S", " ", 8'h00, 8'h00};
    localparam logic [7:0] KW_BITMAP [8] = '{"B", "I", "T", "M", "A", "P", 8'h00, 8'h00};
    localparam logic [7:0] KW_ENDCHAR [8] = '{"E", "N", "D", "C", "H", "A", "R", 8'h00};

    function automatic logic kw_match(line_class_t cls, logic [4:0] pos, logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (cls)
            CL_FONT:    hit = (pos < 5'd16) && (c == KW_FONT[pos[3:0]]);
            CL_CHARS:   hit = (pos < 5'd6) && (c == KW_CHARS[pos[2:0]]);
            CL_BITMAP:  hit = (pos < 5'd6) && (c == KW_BITMAP[pos[2:0]]);
            CL_ENDCHAR: hit = (pos < 5'd7) && (c == KW_ENDCHAR[pos[2:0]]);
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic kw_last(line_class_t cls, logic [4:0] pos);
        logic last;
        last = 1'b0;
        case (cls)
            CL_FONT:    last = (pos == 5'd15);
            CL_CHARS:   last = (pos == 5'd5);
            CL_BITMAP:  last = (pos == 5'd5);
            CL_ENDCHAR: last = (pos == 5'd6);
            default:    last = 1'b0;
        endcase
        return last;
    endfunction

    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= "0" && c <= "9") begin
            v = {1'b1, 4'(c - "0")};
        end else if (c >= "A" && c <= "F") begin
            v = {1'b1, 4'(c - "A" + 8'd10)};
        end else if (c >= "a" && c <= "f") begin
            v = {1'b1, 4'(c - "a" + 8'd10)};
        end
        return v;
    endfunction

    line_class_t   line_class_reg, line_class_next;
    logic [4:0]    line_pos_reg, line_pos_next;
    logic          in_bitmap_reg, in_bitmap_next;
    logic [4:0]    held_reg, held_next;
    logic [1:0]    token_reg, token_next;
    logic [16:0]   acc_reg, acc_next;
    logic [7:0]    box_width_reg, box_width_next;
    logic [7:0]    box_height_reg, box_height_next;
    logic [RW-1:0] glyph_area_reg, glyph_area_next;
    logic [15:0]   glyph_total_reg, glyph_total_next;
    logic [GW-1:0] glyph_index_reg, glyph_index_next;
    logic [AW-1:0] glyph_base_reg;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic [5:0]    hex_column_reg, hex_column_next;

    logic [GW+RW-1:0] base_product;
    logic [AW-1:0]    pix_addr;
    logic [3:0]       pix_mask;
    logic [5:0]       col_inc;
    logic [4:0]       hex;
    logic [19:0]      acc_scaled;
    logic [15:0]      acc_sat;
    logic [15:0]      tok_value;
    logic [7:0]       c;
    logic             res_valid;
    logic             emit;

    assign c = item.text_byte;
    assign hex = hex_value(c);
    assign base_product = (GW+RW)'(glyph_index_reg) * (GW+RW)'(glyph_area_reg);
    assign pix_addr = glyph_base_reg + row_base_reg + AW'({hex_column_reg, 2'b00});
    assign col_inc = (hex_column_reg < 6'd63) ? hex_column_reg + 6'd1 : 6'd63;
    assign tok_value = acc_reg[15:0];
    assign acc_scaled = ({4'd0, acc_reg[15:0]} << 3) + ({4'd0, acc_reg[15:0]} << 1)
                        + 20'(c - "0");
    assign acc_sat = (acc_scaled > 20'd65535) ? 16'hFFFF : acc_scaled[15:0];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            pix_mask[3-j] = (9'({hex_column_reg, 2'b00}) + 9'(j)) < {1'b0, box_width_reg};
        end
    end

    always_comb begin
        line_class_next  = line_class_reg;
        line_pos_next    = line_pos_reg;
        in_bitmap_next   = in_bitmap_reg;
        held_next        = held_reg;
        token_next       = token_reg;
        acc_next         = acc_reg;
        box_width_next   = box_width_reg;
        box_height_next  = box_height_reg;
        glyph_area_next  = glyph_area_reg;
        glyph_total_next = glyph_total_reg;
        glyph_index_next = glyph_index_reg;
        row_base_next    = row_base_reg;
        hex_column_next  = hex_column_reg;
        res_valid        = 1'b0;
        emit             = 1'b0;
        res              = '0;

        if (c == 8'd10) begin
            if (line_class_reg == CL_DATA ||
                (line_class_reg >= CL_FONT && line_class_reg <= CL_ENDCHAR && held_reg[4])) begin
                emit          = held_reg[4];
                row_base_next = row_base_reg + AW'(box_width_reg);
            end else if (line_class_reg == CL_START && in_bitmap_reg) begin
                row_base_next = row_base_reg + AW'(box_width_reg);
            end else if (line_class_reg == CL_NUM) begin
                case (token_reg)
                    2'd0: box_width_next = (tok_value < 16'(bgbp_pkg::W_LIMIT)) ?
                                           tok_value[7:0] : 8'(bgbp_pkg::W_LIMIT);
                    2'd1: box_height_next = (tok_value < 16'(bgbp_pkg::HEIGHT_MAX)) ?
                                            tok_value[7:0] : 8'(bgbp_pkg::HEIGHT_MAX);
                    2'd3: glyph_total_next = tok_value;
                    default: ;
                endcase
                res_valid = 1'b1;
                if (token_reg == 2'd3) begin
                    res.kind = bgbp_pkg::KIND_COUNT;
                end else begin
                    glyph_area_next = RW'(16'(box_width_next) * 16'(box_height_next));
                    res.kind        = bgbp_pkg::KIND_BOX;
                end
            end
        end else begin
            line_pos_next = (line_pos_reg < 5'd31) ? line_pos_reg + 5'd1 : line_pos_reg;
            case (line_class_reg)
                CL_START: begin
                    if (c == "F" || c == "C" || c == "B" || c == "E") begin
                        case (c)
                            "F":     line_class_next = CL_FONT;
                            "C":     line_class_next = CL_CHARS;
                            "B":     line_class_next = CL_BITMAP;
                            default: line_class_next = CL_ENDCHAR;
                        endcase
                        if (in_bitmap_reg) begin
                            held_next = hex;
                        end
                    end else if (in_bitmap_reg) begin
                        line_class_next = CL_DATA;
                        if (hex[4]) begin
                            emit      = held_reg[4];
                            held_next = hex;
                        end
                    end else begin
                        line_class_next = CL_SKIP;
                    end
                end
                CL_FONT, CL_CHARS, CL_BITMAP, CL_ENDCHAR: begin
                    if (kw_match(line_class_reg, line_pos_reg, c)) begin
                        held_next = 5'd0;
                        if (kw_last(line_class_reg, line_pos_reg)) begin
                            case (line_class_reg)
                                CL_FONT: begin
                                    line_class_next = CL_NUM;
                                    token_next      = 2'd0;
                                    acc_next        = 17'd0;
                                end
                                CL_CHARS: begin
                                    line_class_next = CL_NUM;
                                    token_next      = 2'd3;
                                    acc_next        = 17'd0;
                                end
                                CL_BITMAP: begin
                                    in_bitmap_next  = 1'b1;
                                    row_base_next   = '0;
                                    line_class_next = CL_SKIP;
                                end
                                default: begin
                                    in_bitmap_next   = 1'b0;
                                    glyph_index_next = glyph_index_reg + GW'(1);
                                    row_base_next    = '0;
                                    line_class_next  = CL_SKIP;
                                    res_valid        = 1'b1;
                                    res.kind         = bgbp_pkg::KIND_END;
                                    res.glyph_number = 16'(glyph_index_reg);
                                end
                            endcase
                        end
                    end else if (held_reg[4]) begin
                        line_class_next = CL_DATA;
                        if (hex[4]) begin
                            emit      = 1'b1;
                            held_next = hex;
                        end
                    end else begin
                        line_class_next = CL_SKIP;
                    end
                end
                CL_DATA: begin
                    if (hex[4]) begin
                        emit      = held_reg[4];
                        held_next = hex;
                    end
                end
                CL_NUM: begin
                    if (c >= "0" && c <= "9") begin
                        if (!acc_reg[16]) begin
                            acc_next = {1'b0, acc_sat};
                        end
                    end else if (c == " " && token_reg < 2'd2) begin
                        if (token_reg == 2'd0) begin
                            box_width_next = (tok_value < 16'(bgbp_pkg::W_LIMIT)) ?
                                             tok_value[7:0] : 8'(bgbp_pkg::W_LIMIT);
                        end else begin
                            box_height_next = (tok_value < 16'(bgbp_pkg::HEIGHT_MAX)) ?
                                              tok_value[7:0] : 8'(bgbp_pkg::HEIGHT_MAX);
                        end
                        token_next = token_reg + 2'd1;
                        acc_next   = 17'd0;
                    end else if (!(c == " " && token_reg == 2'd2)) begin
                        acc_next = acc_reg | 17'h10000;
                    end
                end
                default: ;
            endcase
        end

        if (emit) begin
            res_valid         = 1'b1;
            res.kind          = bgbp_pkg::KIND_PIXEL;
            res.pixel_address = 24'(pix_addr);
            res.pixel_bits    = held_reg[3:0];
            res.pixel_mask    = pix_mask;
            hex_column_next   = col_inc;
            if (c == 8'd10 || !hex[4]) begin
                held_next = 5'd0;
            end
        end

        if (c == 8'd10) begin
            line_pos_next   = 5'd0;
            line_class_next = CL_START;
            held_next       = 5'd0;
            token_next      = 2'd0;
            acc_next        = 17'd0;
            hex_column_next = 6'd0;
        end

        res.box_width   = box_width_next;
        res.box_height  = box_height_next;
        res.glyph_count = glyph_total_next;
    end

    assign advance  = item.valid && (!res_valid || out_free);
    assign res_load = advance && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_class_reg  <= CL_START;
            line_pos_reg    <= '0;
            in_bitmap_reg   <= 1'b0;
            held_reg        <= '0;
            token_reg       <= '0;
            acc_reg         <= '0;
            box_width_reg   <= '0;
            box_height_reg  <= '0;
            glyph_area_reg  <= '0;
            glyph_total_reg <= '0;
            glyph_index_reg <= '0;
            row_base_reg    <= '0;
            hex_column_reg  <= '0;
        end else if (advance) begin
            line_class_reg  <= line_class_next;
            line_pos_reg    <= line_pos_next;
            in_bitmap_reg   <= in_bitmap_next;
            held_reg        <= held_next;
            token_reg       <= token_next;
            acc_reg         <= acc_next;
            box_width_reg   <= box_width_next;
            box_height_reg  <= box_height_next;
            glyph_area_reg  <= glyph_area_next;
            glyph_total_reg <= glyph_total_next;
            glyph_index_reg <= glyph_index_next;
            row_base_reg    <= row_base_next;
            hex_column_reg  <= hex_column_next;
        end
    end

    // glyph base is registered from index times area; no byte reads it before it catches up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_base_reg <= '0;
        end else begin
            glyph_base_reg <= AW'(base_product);
        end
    end

endmodule

// ===== src/bgbp_out_stage.sv =====
// ----------------------------------------------------------------------------
// bgbp_out_stage
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module bgbp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bgbp_pkg::result_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output bgbp_pkg::result_t m_res
);

    logic              m_valid_reg;
    logic              m_valid_next;
    bgbp_pkg::result_t res_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== src/bdf_glyph_bitmap_parser.sv =====
// ----------------------------------------------------------------------------
// bdf_glyph_bitmap_parser
// Bitmap font text parser. Text bytes enter on the s_ channel, one byte per
// request; each byte yields zero or one result on the m_ channel: a pixel
// nibble with its flat address and mask, a captured bounding box, a captured
// glyph count, or the end of a glyph.
// A result passes from the input register through the single parse stage
// into the result register. Throughput: one byte per cycle while the result
// register is free or the byte yields no result.
// Reset (aresetn low, synchronous) clears all parser state; s_ready is low
// while reset is held and no result is pending afterwards.
// When the receiver stalls, the result register holds its request; bytes
// that yield no result keep flowing, and the input register takes one more
// byte before s_ready drops.
// ----------------------------------------------------------------------------
module bdf_glyph_bitmap_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [23:0] m_pixel_address,
    output logic [3:0]  m_pixel_bits,
    output logic [3:0]  m_pixel_mask,
    output logic [7:0]  m_box_width,
    output logic [7:0]  m_box_height,
    output logic [15:0] m_glyph_count,
    output logic [15:0] m_glyph_number
);

    bgbp_pkg::in_item_t item;
    bgbp_pkg::result_t  res;
    bgbp_pkg::result_t  m_res;
    logic               advance;
    logic               res_load;
    logic               out_free;

    bgbp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .pop         (advance),
        .item        (item)
    );

    bgbp_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .out_free (out_free),
        .advance  (advance),
        .res_load (res_load),
        .res      (res)
    );

    bgbp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_kind          = m_res.kind;
    assign m_pixel_address = m_res.pixel_address;
    assign m_pixel_bits    = m_res.pixel_bits;
    assign m_pixel_mask    = m_res.pixel_mask;
    assign m_box_width     = m_res.box_width;
    assign m_box_height    = m_res.box_height;
    assign m_glyph_count   = m_res.glyph_count;
    assign m_glyph_number  = m_res.glyph_number;

    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    a_pixel_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != bgbp_pkg::KIND_PIXEL) |->
            (m_pixel_address == 24'd0 && m_pixel_bits == 4'd0 && m_pixel_mask == 4'd0))
        else $error("pixel fields set on a non-pixel result");

    a_reset_clears_output: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== test/bgbp_checker.sv =====
// ----------------------------------------------------------------------------
// bgbp_checker
// Watches both channels of the font text parser. Every accepted text byte
// runs through a cycle-free model of the line parser, which queues the
// result it should cause. Every accepted result is compared field by field
// with the oldest queued one. Mismatch and queue depth go to the top.
// ----------------------------------------------------------------------------
module bgbp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [23:0] m_pixel_address,
    input  logic [3:0]  m_pixel_bits,
    input  logic [3:0]  m_pixel_mask,
    input  logic [7:0]  m_box_width,
    input  logic [7:0]  m_box_height,
    input  logic [15:0] m_glyph_count,
    input  logic [15:0] m_glyph_number,
    output int          mismatch_count,
    output int          open_requests
);

    localparam logic [7:0] NEWLINE  = 8'd10;
    localparam logic [2:0] LC_START = 3'd0;
    localparam logic [2:0] LC_KW_F  = 3'd1;
    localparam logic [2:0] LC_KW_C  = 3'd2;
    localparam logic [2:0] LC_KW_B  = 3'd3;
    localparam logic [2:0] LC_KW_E  = 3'd4;
    localparam logic [2:0] LC_DATA  = 3'd5;
    localparam logic [2:0] LC_NUM   = 3'd6;
    localparam logic [2:0] LC_SKIP  = 3'd7;

    localparam logic [1:0] TOK_WIDTH  = 2'd0;
    localparam logic [1:0] TOK_HEIGHT = 2'd1;
    localparam logic [1:0] TOK_EXTRA  = 2'd2;
    localparam logic [1:0] TOK_COUNT  = 2'd3;

    logic [4:0]  line_pos;
    logic [2:0]  line_cls;
    logic        in_glyph;
    logic [4:0]  held_hex;
    logic [1:0]  token_no;
    logic [16:0] number_acc;
    logic [7:0]  box_w;
    logic [7:0]  box_h;
    logic [14:0] glyph_area;
    logic [15:0] count_r;
    logic [15:0] glyph_idx;
    logic [23:0] glyph_origin;
    logic [23:0] row_origin;
    logic [5:0]  hex_col;

    string             keyword_text [4];
    bgbp_pkg::result_t predicted_events [$];
    bgbp_pkg::result_t want;

    initial begin
        keyword_text[0] = "FONTBOUNDINGBOX ";
        keyword_text[1] = "CHARS ";
        keyword_text[2] = "BITMAP";
        keyword_text[3] = "ENDCHAR";
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        return -1;
    endfunction

    task automatic post_event(input bgbp_pkg::kind_t kind, input logic [23:0] addr,
                              input logic [3:0] bits, input logic [3:0] mask,
                              input logic [15:0] number);
        bgbp_pkg::result_t ev;
        ev.kind          = kind;
        ev.pixel_address = addr;
        ev.pixel_bits    = bits;
        ev.pixel_mask    = mask;
        ev.box_width     = box_w;
        ev.box_height    = box_h;
        ev.glyph_count   = count_r;
        ev.glyph_number  = number;
        predicted_events.push_back(ev);
    endtask

    task automatic start_line();
        line_pos   = '0;
        line_cls   = LC_START;
        held_hex   = '0;
        token_no   = TOK_WIDTH;
        number_acc = '0;
        hex_col    = '0;
    endtask

    task automatic clear_parser();
        start_line();
        in_glyph     = 1'b0;
        box_w        = '0;
        box_h        = '0;
        glyph_area   = '0;
        count_r      = '0;
        glyph_idx    = '0;
        glyph_origin = '0;
        row_origin   = '0;
    endtask

    task automatic flush_held_digit();
        logic [3:0] mask;
        int         j;
        if (held_hex[4]) begin
            mask = '0;
            for (j = 0; j < 4; j++) begin
                if (int'(hex_col) * 4 + j < int'(box_w)) mask[3 - j] = 1'b1;
            end
            post_event(bgbp_pkg::KIND_PIXEL,
                       glyph_origin + row_origin + {16'd0, hex_col, 2'b00},
                       held_hex[3:0], mask, '0);
            hex_col  = (hex_col < 6'd63) ? hex_col + 6'd1 : 6'd63;
            held_hex = '0;
        end
    endtask

    task automatic take_row_byte(input logic [7:0] c);
        int h;
        h = hex_value(c);
        if (h >= 0) begin
            flush_held_digit();
            held_hex = {1'b1, 4'(h)};
        end
    endtask

    task automatic close_token();
        logic [15:0] v;
        v = number_acc[15:0];
        case (token_no)
            TOK_WIDTH:  box_w = (v < bgbp_pkg::W_LIMIT) ? v[7:0] : 8'(bgbp_pkg::W_LIMIT);
            TOK_HEIGHT: box_h = (v < bgbp_pkg::HEIGHT_MAX) ? v[7:0] :
                                8'(bgbp_pkg::HEIGHT_MAX);
            TOK_COUNT:  count_r = v;
            default: ;
        endcase
    endtask

    task automatic parse_font_byte(input logic [7:0] c);
        logic [4:0]  pos;
        logic [2:0]  cls;
        logic [15:0] done;
        string       kt;
        int          prod;
        if (c == NEWLINE) begin
            if (line_cls == LC_DATA ||
                (line_cls >= LC_KW_F && line_cls <= LC_KW_E && held_hex[4])) begin
                flush_held_digit();
                row_origin = row_origin + {16'd0, box_w};
            end else if (line_cls == LC_START && in_glyph) begin
                row_origin = row_origin + {16'd0, box_w};
            end else if (line_cls == LC_NUM) begin
                close_token();
                if (token_no == TOK_COUNT) begin
                    post_event(bgbp_pkg::KIND_COUNT, '0, '0, '0, '0);
                end else begin
                    glyph_area   = 15'(16'(box_w) * 16'(box_h));
                    glyph_origin = 24'(32'(glyph_idx) * 32'(glyph_area));
                    post_event(bgbp_pkg::KIND_BOX, '0, '0, '0, '0);
                end
            end
            start_line();
        end else begin
            pos = line_pos;
            cls = line_cls;
            if (line_pos < 5'd31) line_pos = line_pos + 5'd1;
            case (cls)
                LC_START: begin
                    if (c == "F" || c == "C" || c == "B" || c == "E") begin
                        line_cls = (c == "F") ? LC_KW_F : (c == "C") ? LC_KW_C :
                                   (c == "B") ? LC_KW_B : LC_KW_E;
                        if (in_glyph) held_hex = {1'b1, 4'(hex_value(c))};
                    end else if (in_glyph) begin
                        line_cls = LC_DATA;
                        take_row_byte(c);
                    end else begin
                        line_cls = LC_SKIP;
                    end
                end
                LC_KW_F, LC_KW_C, LC_KW_B, LC_KW_E: begin
                    kt = keyword_text[cls - LC_KW_F];
                    if (int'(pos) < kt.len() && c == kt[pos]) begin
                        held_hex = '0;
                        if (int'(pos) + 1 == kt.len()) begin
                            case (cls)
                                LC_KW_F: begin
                                    line_cls   = LC_NUM;
                                    token_no   = TOK_WIDTH;
                                    number_acc = '0;
                                end
                                LC_KW_C: begin
                                    line_cls   = LC_NUM;
                                    token_no   = TOK_COUNT;
                                    number_acc = '0;
                                end
                                LC_KW_B: begin
                                    in_glyph   = 1'b1;
                                    row_origin = '0;
                                    line_cls   = LC_SKIP;
                                end
                                default: begin
                                    done         = glyph_idx;
                                    in_glyph     = 1'b0;
                                    glyph_idx    = glyph_idx + 16'd1;
                                    glyph_origin = 24'(32'(glyph_idx) * 32'(glyph_area));
                                    row_origin   = '0;
                                    post_event(bgbp_pkg::KIND_END, '0, '0, '0, done);
                                    line_cls     = LC_SKIP;
                                end
                            endcase
                        end
                    end else if (held_hex[4]) begin
                        line_cls = LC_DATA;
                        take_row_byte(c);
                    end else begin
                        line_cls = LC_SKIP;
                    end
                end
                LC_DATA: take_row_byte(c);
                LC_NUM: begin
                    if (c >= "0" && c <= "9") begin
                        if (!number_acc[16]) begin
                            prod = int'(number_acc[15:0]) * 10 + int'(c) - 48;
                            number_acc = (prod > 65535) ? 17'd65535 : 17'(prod);
                        end
                    end else if (c == " " && token_no < TOK_EXTRA) begin
                        close_token();
                        token_no   = token_no + 2'd1;
                        number_acc = '0;
                    end else if (!(c == " " && token_no == TOK_EXTRA)) begin
                        number_acc[16] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] expected_value,
                               input logic [23:0] actual_value);
        if (actual_value !== expected_value) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected_value, actual_value);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            predicted_events.delete();
        end else begin
            if (s_valid && s_ready) parse_font_byte(s_text_byte);
            if (m_valid && m_ready) begin
                if (predicted_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual kind %0d",
                             $time, m_kind,
                             " addr %0h bits %0h mask %0h box %0d x %0d count %0d glyph %0d",
                             m_pixel_address, m_pixel_bits, m_pixel_mask, m_box_width,
                             m_box_height, m_glyph_count, m_glyph_number);
                end else begin
                    want = predicted_events.pop_front();
                    check_field("kind", 24'(want.kind), 24'(m_kind));
                    check_field("pixel_address", want.pixel_address, m_pixel_address);
                    check_field("pixel_bits", 24'(want.pixel_bits), 24'(m_pixel_bits));
                    check_field("pixel_mask", 24'(want.pixel_mask), 24'(m_pixel_mask));
                    check_field("box_width", 24'(want.box_width), 24'(m_box_width));
                    check_field("box_height", 24'(want.box_height), 24'(m_box_height));
                    check_field("glyph_count", 24'(want.glyph_count), 24'(m_glyph_count));
                    check_field("glyph_number", 24'(want.glyph_number),
                                24'(m_glyph_number));
                end
            end
        end
        open_requests = predicted_events.size();
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds the font text parser with directed font lines, glyph end bursts
// that move the glyph origin, a receiver hold-off that backs up the
// input, and random font text with broken lines and noise mixed in. Both
// sides idle at random. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         RANDOM_BYTES = 150;
    localparam int         LONG_HOLD    = 400;
    localparam logic [7:0] NEWLINE      = 8'd10;
    localparam logic [7:0] CARRIAGE     = 8'd13;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [23:0] m_pixel_address;
    logic [3:0]  m_pixel_bits;
    logic [3:0]  m_pixel_mask;
    logic [7:0]  m_box_width;
    logic [7:0]  m_box_height;
    logic [15:0] m_glyph_count;
    logic [15:0] m_glyph_number;

    int mismatch_count;
    int open_requests;
    int bytes_sent;
    int results_taken;
    int cycles;
    int row_width;
    bit burst_mode;
    bit hold_request;

    bdf_glyph_bitmap_parser i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pixel_address (m_pixel_address),
        .m_pixel_bits    (m_pixel_bits),
        .m_pixel_mask    (m_pixel_mask),
        .m_box_width     (m_box_width),
        .m_box_height    (m_box_height),
        .m_glyph_count   (m_glyph_count),
        .m_glyph_number  (m_glyph_number)
    );

    bgbp_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pixel_address (m_pixel_address),
        .m_pixel_bits    (m_pixel_bits),
        .m_pixel_mask    (m_pixel_mask),
        .m_box_width     (m_box_width),
        .m_box_height    (m_box_height),
        .m_glyph_count   (m_glyph_count),
        .m_glyph_number  (m_glyph_number),
        .mismatch_count  (mismatch_count),
        .open_requests   (open_requests)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    results_taken++;
                    hold = (results_taken % 200 < 40) ? 0 : $urandom_range(0, 16);
                end
                if (hold_request) begin
                    hold         = LONG_HOLD;
                    hold_request = 1'b0;
                end
            end
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_text_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line(input string text);
        int i;
        for (i = 0; i < text.len(); i++) send_byte(text[i]);
        send_byte(NEWLINE);
    endtask

    task automatic send_noise_line();
        int         n;
        int         i;
        logic [7:0] b;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == NEWLINE) b = 8'd0;
            send_byte(b);
        end
        send_byte(NEWLINE);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (open_requests != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic string hex_row(input int digits);
        string row;
        int    v;
        int    i;
        row = "";
        for (i = 0; i < digits; i++) begin
            v = $urandom_range(0, 15);
            if (v < 10) row = $sformatf("%s%c", row, 48 + v);
            else row = $sformatf("%s%c", row, ($urandom_range(0, 1) ? 65 : 97) + v - 10);
        end
        return row;
    endfunction

    task automatic send_box_line();
        int w;
        int h;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 10);
        case ($urandom_range(0, 3))
            0: send_line($sformatf("FONTBOUNDINGBOX %0d", w));
            1: send_line($sformatf("FONTBOUNDINGBOX %0d %0d", w, h));
            default: send_line($sformatf("FONTBOUNDINGBOX %0d %0d %0d -%0d", w, h,
                                         $urandom_range(0, 9), $urandom_range(0, 9)));
        endcase
        row_width = (w < bgbp_pkg::W_LIMIT) ? w : bgbp_pkg::W_LIMIT;
    endtask

    task automatic send_glyph(input int rows, input bit open_ended);
        int    digits;
        int    sel;
        string text;
        if ($urandom_range(0, 1)) send_line($sformatf("STARTCHAR g%0d", $urandom_range(0, 999)));
        if ($urandom_range(0, 1)) send_line($sformatf("ENCODING %0d", $urandom_range(0, 255)));
        send_line("BITMAP");
        digits = (row_width + 3) / 4;
        if (digits == 0) digits = 1;
        repeat (rows) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                send_line("");
            end else if (sel == 1) begin
                send_noise_line();
            end else begin
                text = hex_row(digits + ((sel == 2) ? $urandom_range(1, 4) : 0));
                if (sel == 3) text = {text, " ", hex_row(1)};
                if (sel == 4) text = $sformatf("%s%c", text, CARRIAGE);
                send_line(text);
            end
        end
        if (!open_ended) send_line("ENDCHAR");
    endtask

    task automatic send_broken_line();
        case ($urandom_range(0, 5))
            0: send_line("FONTBOUND 3");
            1: send_line("CHARS");
            2: send_line("BITMA");
            3: send_line("ENDCHA");
            4: send_line("CHARS12");
            default: send_line("Fx 7");
        endcase
    endtask

    initial begin
        int sel;
        int random_end;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_text_byte  = 8'd0;
        burst_mode   = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        results_taken = 0;
        row_width    = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        send_line("FONTBOUNDINGBOX 300 200 0 -2");
        send_line("CHARS 99999");
        send_line("CHARS -7");
        send_line("CHARS 12 34");
        send_line("fontboundingbox 8 8");
        send_line("FONTBOUNDINGBOX  4");
        send_line("FONTBOUNDINGBOX 6");
        send_line("FONTBOUNDINGBOX 7777777 5x9");
        send_line("ENDCHAR");
        send_line("FONTBOUNDINGBOX 10 3 0 0");
        send_line("BITMAPXYZ");
        send_line("BA5");
        send_line("C3");
        send_line("E");
        send_line("Fo");
        send_line("");
        send_line("DE AD");
        send_line($sformatf("Ab9z1%c", CARRIAGE));
        send_line("ENDCHAR junk");
        send_line("BITMAP");
        send_line(hex_row(70));
        send_line("ENDCHAR");
        wait_drained();

        // back up the result path while bytes keep coming
        row_width = 128;
        send_line("FONTBOUNDINGBOX 128 8");
        send_line("BITMAP");
        burst_mode   = 1'b1;
        hold_request = 1'b1;
        repeat (3) send_line(hex_row(32));
        send_line("ENDCHAR");
        burst_mode = 1'b0;
        wait_drained();

        // advance the glyph origin over several glyphs
        send_line("FONTBOUNDINGBOX 128 128");
        burst_mode = 1'b1;
        repeat (6) send_line("ENDCHAR");
        burst_mode = 1'b0;
        send_glyph(2, 1'b0);
        burst_mode = 1'b1;
        repeat (6) send_line("ENDCHAR");
        burst_mode = 1'b0;
        send_glyph(2, 1'b0);
        wait_drained();

        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end) begin
            burst_mode = ($urandom_range(0, 7) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 10) send_box_line();
            else if (sel < 15) send_line($sformatf("CHARS %0d", $urandom_range(0, 70000)));
            else if (sel < 80) send_glyph($urandom_range(0, 6), $urandom_range(0, 9) == 0);
            else if (sel < 90) send_noise_line();
            else send_broken_line();
        end
        burst_mode = 1'b0;

        wait_drained();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bgbp_pkg.sv
src/bgbp_in_stage.sv
src/bgbp_parse.sv
src/bgbp_out_stage.sv
src/bdf_glyph_bitmap_parser.sv
test/bgbp_checker.sv
test/testbench.sv
